@@ rtl/fdr_pkg.sv @@
`default_nettype none
package fdr_pkg;

  localparam int COS_W      = 16;
  localparam int ETA_W      = 15;
  localparam int OUT_W      = 16;
  localparam int COS_FRAC   = 14;
  localparam int ETA_FRAC   = 13;
  localparam int OUT_FRAC   = 15;

  localparam int MAG_W      = COS_W;
  localparam int C2_W       = 2 * MAG_W;
  localparam int SI2_W      = 2 * COS_FRAC + 1;
  localparam int ETA2_W     = 2 * ETA_W;
  localparam int LHS_W      = SI2_W + ETA2_W;
  localparam int ST2_W      = 2 * COS_FRAC;
  localparam int CT_W       = COS_FRAC + 1;
  localparam int PROD_W     = ETA_W + MAG_W;
  localparam int DEN_W      = PROD_W + 1;
  localparam int NUM_W      = PROD_W + OUT_FRAC + 1;
  localparam int R_W        = OUT_FRAC + 1;
  localparam int SQ_W       = 2 * R_W;

  localparam logic [C2_W-1:0]  ONE_C2   = C2_W'(1) << (2 * COS_FRAC);
  localparam logic [OUT_W:0]   ONE_OUT  = (OUT_W + 1)'(1) << OUT_FRAC;
  localparam logic [ETA_W-1:0] ETA_ONE  = ETA_W'(1) << ETA_FRAC;

  localparam logic REG_ETA_OUTSIDE = 1'b0;
  localparam logic REG_ETA_INSIDE  = 1'b1;

endpackage
`default_nettype wire

@@ rtl/fdr_div_pipe.sv @@
`default_nettype none
module fdr_div_pipe #(
  parameter int NUM_W  = 47,
  parameter int DEN_W  = 32,
  parameter int QUO_W  = 16,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   out_valid,
  output logic [QUO_W-1:0]       quo,
  output logic [SIDE_W-1:0]      side_out
);

  localparam int W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  // restoring division, one quotient bit per stage; num < den << QUO_W
  logic [W-1:0]      rem [QUO_W];
  logic [DEN_W-1:0]  dv  [QUO_W];
  logic [QUO_W-1:0]  qv  [QUO_W+1];
  logic [SIDE_W-1:0] sd  [QUO_W+1];
  logic [QUO_W:0]    vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QUO_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= W'(num);
      dv[0]  <= den;
      qv[0]  <= '0;
      sd[0]  <= side_in;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int B = QUO_W - 1 - k;
    logic [W-1:0] trial;
    logic         ge;
    assign trial = W'(dv[k]) << B;
    assign ge    = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        qv[k+1] <= qv[k] | (QUO_W'(ge) << B);
        sd[k+1] <= sd[k];
      end
    end

    if (k < QUO_W - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= ge ? rem[k] - trial : rem[k];
          dv[k+1]  <= dv[k];
        end
      end
    end
  end

  assign out_valid = vld[QUO_W];
  assign quo       = qv[QUO_W];
  assign side_out  = sd[QUO_W];

endmodule
`default_nettype wire

@@ rtl/fresnel_dielectric_reflectance_core.sv @@
`default_nettype none
// Throughput: one beat per cycle; every stage moves under one enable, so the
// pipeline only holds when the output register is full and m_tready is low.
// The three long stretches are the sin^2 divider, the square root steps and the ratio dividers.
// Reset (rst, synchronous) empties the pipeline and sets both indices to 1.0.
module fresnel_dielectric_reflectance_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [fdr_pkg::COS_W-1:0]   s_tdata,   // [15:0] cos_incident
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [fdr_pkg::OUT_W-1:0]        m_tdata,   // [15:0] reflectance
  output logic                             m_tuser,   // [0] total_internal
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [fdr_pkg::ETA_W-1:0]   cfg_data
);
  import fdr_pkg::*;

  logic en;
  logic [ETA_W-1:0] eta_outside, eta_inside;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      eta_outside <= ETA_ONE;
      eta_inside  <= ETA_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ETA_OUTSIDE: eta_outside <= cfg_data;
        REG_ETA_INSIDE:  eta_inside  <= cfg_data;
        default:         eta_outside <= eta_outside;
      endcase
    end
  end

  // stage A: magnitude and side selection
  logic             a_vld;
  logic [MAG_W-1:0] a_mag;
  logic [ETA_W-1:0] a_ei, a_et;
  logic             neg, entering;

  assign neg      = s_tdata[COS_W-1];
  assign entering = !neg && (s_tdata != '0);

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (en) a_vld <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag <= neg ? MAG_W'(-s_tdata) : MAG_W'(s_tdata);
      a_ei  <= entering ? eta_outside : eta_inside;
      a_et  <= entering ? eta_inside : eta_outside;
    end
  end

  // stage B: squares
  logic              b_vld;
  logic [C2_W-1:0]   b_c2;
  logic [ETA2_W-1:0] b_ei2, b_et2;
  logic [MAG_W-1:0]  b_mag;
  logic [ETA_W-1:0]  b_ei, b_et;

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (en) b_vld <= a_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_c2  <= C2_W'(a_mag) * C2_W'(a_mag);
      b_ei2 <= ETA2_W'(a_ei) * ETA2_W'(a_ei);
      b_et2 <= ETA2_W'(a_et) * ETA2_W'(a_et);
      b_mag <= a_mag;
      b_ei  <= a_ei;
      b_et  <= a_et;
    end
  end

  // stage C: sin^2 of incidence times ei^2
  logic              c_vld;
  logic [LHS_W-1:0]  c_lhs;
  logic [ETA2_W-1:0] c_et2;
  logic [MAG_W-1:0]  c_mag;
  logic [ETA_W-1:0]  c_ei, c_et;
  logic [SI2_W-1:0]  si2;

  assign si2 = (b_c2 >= ONE_C2) ? '0 : SI2_W'(ONE_C2 - b_c2);

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else if (en) c_vld <= b_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_lhs <= LHS_W'(si2) * LHS_W'(b_ei2);
      c_et2 <= b_et2;
      c_mag <= b_mag;
      c_ei  <= b_ei;
      c_et  <= b_et;
    end
  end

  // divide for sin^2 of transmission
  localparam int SIDE1_W = 1 + MAG_W + 2 * ETA_W;
  logic               tir_c;
  logic               d1_vld;
  logic [ST2_W-1:0]   st2;
  logic [SIDE1_W-1:0] d1_side;

  assign tir_c = c_lhs >= (LHS_W'(c_et2) << (2 * COS_FRAC));

  fdr_div_pipe #(
    .NUM_W (LHS_W),
    .DEN_W (ETA2_W),
    .QUO_W (ST2_W),
    .SIDE_W(SIDE1_W)
  ) u_div_st2 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c_vld),
    .num      (c_lhs),
    .den      (c_et2),
    .side_in  ({tir_c, c_mag, c_ei, c_et}),
    .out_valid(d1_vld),
    .quo      (st2),
    .side_out (d1_side)
  );

  // square root, one root bit per step
  logic [SI2_W-1:0]   sq_rem  [CT_W];
  logic [CT_W-1:0]    sq_root [CT_W+1];
  logic [SIDE1_W-1:0] sq_side [CT_W+1];
  logic [CT_W:0]      sq_vld;

  always_ff @(posedge clk) begin
    if (rst) sq_vld <= '0;
    else if (en) sq_vld <= {sq_vld[CT_W-1:0], d1_vld};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= SI2_W'(ONE_C2) - SI2_W'(st2);
      sq_root[0] <= '0;
      sq_side[0] <= d1_side;
    end
  end

  for (genvar j = 0; j < CT_W; j++) begin : g_sqrt
    localparam int K = CT_W - 1 - j;
    logic [2*CT_W-1:0] inc;
    logic              ge;
    assign inc = ((2 * CT_W)'(sq_root[j]) << (K + 1)) + ((2 * CT_W)'(1) << (2 * K));
    assign ge  = (2 * CT_W)'(sq_rem[j]) >= inc;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_root[j+1] <= sq_root[j] | (CT_W'(ge) << K);
        sq_side[j+1] <= sq_side[j];
      end
    end

    if (j < CT_W - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) sq_rem[j+1] <= ge ? SI2_W'((2 * CT_W)'(sq_rem[j]) - inc) : sq_rem[j];
      end
    end
  end

  // stage F: amplitude products
  logic              f_vld, f_tir;
  logic [PROD_W-1:0] f_a, f_b, f_p, f_q;
  logic [CT_W-1:0]   ct;
  logic [MAG_W-1:0]  e_mag;
  logic [ETA_W-1:0]  e_ei, e_et;
  logic              e_tir;

  assign ct = sq_root[CT_W];
  assign {e_tir, e_mag, e_ei, e_et} = sq_side[CT_W];

  always_ff @(posedge clk) begin
    if (rst) f_vld <= 1'b0;
    else if (en) f_vld <= sq_vld[CT_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_tir <= e_tir;
      f_a   <= PROD_W'(e_et) * PROD_W'(e_mag);
      f_b   <= PROD_W'(e_ei) * PROD_W'(ct);
      f_p   <= PROD_W'(e_ei) * PROD_W'(e_mag);
      f_q   <= PROD_W'(e_et) * PROD_W'(ct);
    end
  end

  // sums, differences and the two ratio dividers
  logic [DEN_W-1:0]  den1, den2;
  logic [PROD_W-1:0] dif1, dif2;
  logic [NUM_W-1:0]  num1, num2;
  logic              dz;
  logic              r1_vld, r2_vld, r_tir, r_dz;
  logic [R_W-1:0]    r1, r2;

  assign den1 = DEN_W'(f_a) + DEN_W'(f_b);
  assign den2 = DEN_W'(f_p) + DEN_W'(f_q);
  assign dif1 = (f_a >= f_b) ? f_a - f_b : f_b - f_a;
  assign dif2 = (f_p >= f_q) ? f_p - f_q : f_q - f_p;
  assign num1 = (NUM_W'(dif1) << OUT_FRAC) + NUM_W'(den1 >> 1);
  assign num2 = (NUM_W'(dif2) << OUT_FRAC) + NUM_W'(den2 >> 1);
  assign dz   = (den1 == '0) || (den2 == '0);

  fdr_div_pipe #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (R_W),
    .SIDE_W(1)
  ) u_div_r1 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_vld),
    .num      (num1),
    .den      (den1),
    .side_in  (f_tir),
    .out_valid(r1_vld),
    .quo      (r1),
    .side_out (r_tir)
  );

  fdr_div_pipe #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (R_W),
    .SIDE_W(1)
  ) u_div_r2 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_vld),
    .num      (num2),
    .den      (den2),
    .side_in  (dz),
    .out_valid(r2_vld),
    .quo      (r2),
    .side_out (r_dz)
  );

  // stage H: squared coefficients
  logic            h_vld, h_tir, h_dz;
  logic [SQ_W-1:0] h_s1, h_s2;

  always_ff @(posedge clk) begin
    if (rst) h_vld <= 1'b0;
    else if (en) h_vld <= r1_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_s1  <= SQ_W'(r1) * SQ_W'(r1);
      h_s2  <= SQ_W'(r2) * SQ_W'(r2);
      h_tir <= r_tir;
      h_dz  <= r_dz;
    end
  end

  // output register: average, round, saturate
  logic [SQ_W:0]  sum;
  logic [OUT_W:0] rnd;
  logic [OUT_W-1:0] refl;

  assign sum  = (SQ_W + 1)'(h_s1) + (SQ_W + 1)'(h_s2) + (SQ_W + 1)'(ONE_OUT);
  assign rnd  = (OUT_W + 1)'(sum >> (OUT_FRAC + 1));
  assign refl = (h_tir || h_dz || rnd > ONE_OUT) ? OUT_W'(ONE_OUT) : OUT_W'(rnd);

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= h_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= refl;
      m_tuser <= h_tir;
    end
  end

  a_tir_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == OUT_W'(ONE_OUT))
    else $error("total internal beat without full reflectance");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata <= OUT_W'(ONE_OUT))
    else $error("reflectance above one");

  a_div_lock: assert property (@(posedge clk) disable iff (rst)
    r1_vld == r2_vld)
    else $error("ratio dividers out of step");

endmodule
`default_nettype wire

@@ dv/fdr_checker.sv @@
`timescale 1ns / 100ps
module fdr_checker (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  input  wire logic                      s_tready,
  input  wire logic [fdr_pkg::COS_W-1:0] s_tdata,
  input  wire logic                      m_tvalid,
  input  wire logic                      m_tready,
  input  wire logic [fdr_pkg::OUT_W-1:0] m_tdata,
  input  wire logic                      m_tuser,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [fdr_pkg::ETA_W-1:0] cfg_data,
  output int                             errors,
  output int                             outstanding,
  output int                             checked,
  output int                             tir_seen
);
  import fdr_pkg::*;

  typedef struct packed {
    logic             tir;
    logic [OUT_W-1:0] refl;
  } reflect_t;

  logic [ETA_W-1:0] eta_out_q;
  logic [ETA_W-1:0] eta_in_q;
  reflect_t         pending_q[$];

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned amp_ratio(longint unsigned x, longint unsigned y,
                                                longint unsigned den);
    longint unsigned diff;
    diff = (x >= y) ? x - y : y - x;
    return ((diff << OUT_FRAC) + (den >> 1)) / den;
  endfunction

  function automatic reflect_t fresnel_predict(logic [COS_W-1:0] c,
                                               logic [ETA_W-1:0] eo, logic [ETA_W-1:0] ein);
    reflect_t        r;
    longint unsigned one_c2, one_o, mag, n_i, n_t, c2, si2, lhs, nt2, st2, ct;
    longint unsigned a, b, p, q, d1, d2, r1, r2, sum, refl;
    logic            entering;
    one_c2   = 64'd1 << (2 * COS_FRAC);
    one_o    = 64'd1 << OUT_FRAC;
    entering = !c[COS_W-1] && (c != 0);
    mag      = c[COS_W-1] ? 64'h10000 - longint'(c) : longint'(c);
    n_i      = entering ? eo : ein;
    n_t      = entering ? ein : eo;
    c2       = mag * mag;
    si2      = (c2 >= one_c2) ? 0 : one_c2 - c2;
    lhs      = si2 * n_i * n_i;
    nt2      = n_t * n_t;
    r.tir    = 1'b0;
    r.refl   = OUT_W'(one_o);
    // total internal reflection, including a zero far-side index
    if (lhs >= (nt2 << (2 * COS_FRAC))) begin
      r.tir = 1'b1;
      return r;
    end
    st2 = lhs / nt2;
    ct  = floor_root(one_c2 - st2);
    a   = n_t * mag;
    b   = n_i * ct;
    p   = n_i * mag;
    q   = n_t * ct;
    d1  = a + b;
    d2  = p + q;
    if (d1 == 0 || d2 == 0) return r;
    r1   = amp_ratio(a, b, d1);
    r2   = amp_ratio(p, q, d2);
    sum  = r1 * r1 + r2 * r2;
    refl = (sum + one_o) >> (OUT_FRAC + 1);
    if (refl > one_o) refl = one_o;
    r.refl = OUT_W'(refl);
    return r;
  endfunction

  assign outstanding = pending_q.size();

  always @(posedge clk) begin
    reflect_t want;
    int       bad;
    bad = 0;
    if (rst) begin
      eta_out_q <= ETA_ONE;
      eta_in_q  <= ETA_ONE;
      errors    <= 0;
      checked   <= 0;
      tir_seen  <= 0;
      pending_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ETA_OUTSIDE) eta_out_q <= cfg_data;
        else if (cfg_index == REG_ETA_INSIDE) eta_in_q <= cfg_data;
      end
      if (s_tvalid && s_tready) pending_q.push_back(fresnel_predict(s_tdata, eta_out_q, eta_in_q));
      if (m_tvalid && m_tready) begin
        if (pending_q.size() == 0) begin
          $error("result beat with nothing pending: reflectance %0d total_internal %0d",
                 m_tdata, m_tuser);
          bad = bad + 1;
        end else begin
          want = pending_q.pop_front();
          checked <= checked + 1;
          if (m_tuser) tir_seen <= tir_seen + 1;
          if (want.refl !== m_tdata) begin
            $error("reflectance: expected %0d, got %0d", want.refl, m_tdata);
            bad = bad + 1;
          end
          if (want.tir !== m_tuser) begin
            $error("total_internal: expected %0d, got %0d", want.tir, m_tuser);
            bad = bad + 1;
          end
        end
      end
      errors <= errors + bad;
    end
  end
endmodule

@@ dv/tb_fresnel_dielectric_reflectance_core.sv @@
`timescale 1ns / 100ps
module tb_fresnel_dielectric_reflectance_core;
  import fdr_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int N_PHASES     = 10;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [COS_W-1:0] s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_ETA_OUTSIDE;
  logic [ETA_W-1:0] cfg_data = '0;
  int               errors, outstanding, checked, tir_seen;
  int               cycles = 0;
  int               sent = 0;
  bit               rx_started = 1'b0;

  logic [ETA_W-1:0] eta_out_set[N_PHASES] =
    '{15'd8192, 15'd8192, 15'd12288, 15'd32767, 15'd8192, 15'd32767,
      15'd10923, 15'd8192, 15'd0, 15'd0};
  logic [ETA_W-1:0] eta_in_set[N_PHASES] =
    '{15'd8192, 15'd12288, 15'd8192, 15'd8192, 15'd32767, 15'd32767,
      15'd9000, 15'd0, 15'd8192, 15'd0};
  logic [COS_W-1:0] edge_cos[14] =
    '{16'h0000, 16'h4000, 16'hC000, 16'h0001, 16'hFFFF, 16'h2000, 16'hE000,
      16'h7FFF, 16'h8000, 16'h4001, 16'hBFFF, 16'h2D41, 16'hD2BF, 16'h5555};

  fresnel_dielectric_reflectance_core i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_we, .cfg_index, .cfg_data
  );

  fdr_checker i_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_we, .cfg_index, .cfg_data,
    .errors, .outstanding, .checked, .tir_seen
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_fresnel_dielectric_reflectance_core: done, errors");
      $finish;
    end
  end

  // receiver: one long hold-off at the start, then random stall patterns
  initial begin
    int mode, len;
    wait (rx_started);
    repeat (400) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 19);
      len  = $urandom_range(10, 80);
      if (mode == 0) len = 200;
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0:        m_tready <= 1'b0;
          1, 2, 3:  m_tready <= 1'b1;
          4, 5:     m_tready <= ($urandom_range(0, 9) == 0);
          default:  m_tready <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  task automatic send_beat(input logic [COS_W-1:0] v);
    logic hs;
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do begin
      @(negedge clk);
      hs = s_tready;
      @(posedge clk);
    end while (!hs);
    sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [ETA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  function automatic logic [COS_W-1:0] pick_cos();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return edge_cos[$urandom_range(0, 13)];
    if (sel < 3) return COS_W'($urandom);
    return COS_W'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  initial begin
    int burst, gap, n_items;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    rx_started = 1'b1;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      // hold until the pipeline has drained, then reconfigure
      while (outstanding != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      write_reg(REG_ETA_OUTSIDE, eta_out_set[ph]);
      write_reg(REG_ETA_INSIDE, eta_in_set[ph]);
      cfg_we <= 1'b0;
      @(posedge clk);
      if (ph == 0) foreach (edge_cos[k]) send_beat(edge_cos[k]);
      n_items = (ph >= 7) ? 40 : 90;
      while (n_items > 0) begin
        burst = $urandom_range(1, 24);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        for (int k = 0; k < burst && n_items > 0; k++) begin
          send_beat(pick_cos());
          n_items--;
        end
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    while (outstanding != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("covered %0d beats over %0d index settings (zero indices included)",
             sent, N_PHASES);
    $display("checked %0d results, %0d with total internal reflection", checked, tir_seen);
    if (errors == 0 && outstanding == 0) begin
      $display("tb_fresnel_dielectric_reflectance_core: done, clean");
    end else begin
      $display("tb_fresnel_dielectric_reflectance_core: done, errors");
    end
    $finish;
  end
endmodule

@@ fresnel_dielectric_reflectance_core.f @@
rtl/fdr_pkg.sv
rtl/fdr_div_pipe.sv
rtl/fresnel_dielectric_reflectance_core.sv
dv/fdr_checker.sv
dv/tb_fresnel_dielectric_reflectance_core.sv
